/* design/byte_ring_frame_extractor_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring frame extractor
// Shared property forms; each use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FRAME_EXTRACTOR_MACROS_SVH
`define BYTE_RING_FRAME_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define BRFE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRFE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/brfe_pkg.sv */
// ----------------------------------------------------------------------------
// brfe_pkg
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
package brfe_pkg;

  localparam int BUFFER_DEPTH_DEF      = 64;
  localparam int MAX_PATTERN_BYTES_DEF = 8;

  // counter width: holds sums of a position, an offset and a pattern length
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_PATTERN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LENGTH = 3'd5;

  localparam logic [1:0] MODE_HEAD_TAIL = 2'd0;
  localparam logic [1:0] MODE_HEAD_LEN  = 2'd1;
  localparam logic [1:0] MODE_LEN_ONLY  = 2'd2;
  localparam logic [1:0] MODE_NEXT_HEAD = 2'd3;

  localparam logic KIND_WRITE = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_WRITE,
    OP_START,
    OP_READ,
    OP_CHK_NEXT,
    OP_OUTER_NEXT,
    OP_INNER_INIT,
    OP_INNER_NEXT,
    OP_FOUND,
    OP_EMIT_RD,
    OP_EMIT_LOAD,
    OP_LOAD_NF,
    OP_LOAD_W
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   inner;
  } dp_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] mode;
    logic       pre_ok;
    logic       outer_ok;
    logic       inner_ok;
    logic       chk_done;
    logic       chk_oob;
    logic       byte_eq;
    logic       size_zero;
    logic       emit_last;
    logic       out_busy;
  } dp_sts_t;

endpackage

/* design/brfe_in_if.sv */
// ----------------------------------------------------------------------------
// brfe_in_if
// Input item channel: write or extract request.
// ----------------------------------------------------------------------------
interface brfe_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       chunk_first;
  logic [5:0] chunk_length;

  modport source (output valid, kind, data_byte, chunk_first, chunk_length, input ready);
  modport sink (input valid, kind, data_byte, chunk_first, chunk_length, output ready);
endinterface

/* design/brfe_out_if.sv */
// ----------------------------------------------------------------------------
// brfe_out_if
// Result item channel.
// ----------------------------------------------------------------------------
interface brfe_out_if;
  logic       valid;
  logic       ready;
  logic       write_accepted;
  logic       found;
  logic [7:0] frame_byte;
  logic [5:0] frame_size;
  logic       last;

  modport source (output valid, write_accepted, found, frame_byte, frame_size, last,
                  input ready);
  modport sink (input valid, write_accepted, found, frame_byte, frame_size, last,
                output ready);
endinterface

/* design/brfe_cfg_if.sv */
// ----------------------------------------------------------------------------
// brfe_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface brfe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [brfe_pkg::CFG_IDX_W-1:0]     index;
  logic [brfe_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/brfe_datapath.sv */
// ----------------------------------------------------------------------------
// brfe_datapath
// Byte store, pointers, search counters, configuration and result register.
// ----------------------------------------------------------------------------
`include "byte_ring_frame_extractor_macros.svh"

module brfe_datapath #(
  parameter int BUFFER_DEPTH      = brfe_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_PATTERN_BYTES = brfe_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  brfe_pkg::dp_cmd_t               cmd,
  output brfe_pkg::dp_sts_t               sts,
  input  logic                            in_kind,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_chunk_first,
  input  logic [5:0]                      in_chunk_length,
  input  logic                            cfg_we,
  input  logic [brfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brfe_pkg::CFG_DATA_W-1:0] cfg_data,
  brfe_out_if.source                      out_ch
);
  import brfe_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int PB = 8 * MAX_PATTERN_BYTES;
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] MAXP  = CNT_W'(MAX_PATTERN_BYTES);

  function automatic logic [PW-1:0] wrap(input logic [CNT_W-1:0] v);
    if (v >= DEPTH) begin
      return PW'(v - DEPTH);
    end
    return PW'(v);
  endfunction

  // configuration
  logic [1:0]    mode_r;
  logic [PB-1:0] head_pat;
  logic [3:0]    head_cnt;
  logic [PB-1:0] tail_pat;
  logic [3:0]    tail_cnt;
  logic [5:0]    fixed_len;

  // control state
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic          chunk_acc;
  logic          out_valid;

  // working registers
  logic             kind_r;
  logic [7:0]       data_r;
  logic             first_r;
  logic [5:0]       clen_r;
  logic             stored_r;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] s;
  logic [CNT_W-1:0] ti;
  logic [CNT_W-1:0] x;
  logic [CNT_W-1:0] start_r;
  logic [CNT_W-1:0] size_r;
  logic [CNT_W-1:0] k;
  logic [7:0]       rdata;
  logic [7:0]       mem [BUFFER_DEPTH];

  logic             wr_acc;
  logic             wr_store;
  logic [CNT_W-1:0] h;
  logic [CNT_W-1:0] t;
  logic [CNT_W-1:0] nfix;
  logic [CNT_W-1:0] c2;
  logic [CNT_W-1:0] csel;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] stored_len;
  logic [CNT_W-1:0] rd_off;
  logic [PW-1:0]    rd_addr;
  logic [PB-1:0]    pat_sel;
  logic [7:0]       pbyte;

  always_comb begin
    h    = (CNT_W'(head_cnt) > MAXP) ? MAXP : CNT_W'(head_cnt);
    t    = (CNT_W'(tail_cnt) > MAXP) ? MAXP : CNT_W'(tail_cnt);
    nfix = CNT_W'(fixed_len);
    c2   = (mode_r == MODE_NEXT_HEAD) ? h : t;
    csel = cmd.inner ? c2 : h;
    pos  = cmd.inner ? (s + ti) : s;
    pat_sel = (cmd.inner && mode_r == MODE_HEAD_TAIL) ? tail_pat : head_pat;
    pbyte   = 8'(pat_sel >> {x, 3'b000});
    stored_len = (wp >= rp) ? (CNT_W'(wp) - CNT_W'(rp))
                            : (CNT_W'(wp) + DEPTH - CNT_W'(rp));
    room   = DEPTH - CNT_W'(1) - len;
    wr_acc   = first_r ? (CNT_W'(clen_r) <= room) : chunk_acc;
    wr_store = wr_acc && (room != '0);
    rd_off  = (cmd.op == OP_EMIT_RD) ? (start_r + k) : (pos + x);
    rd_addr = wrap(CNT_W'(rp) + rd_off);
  end

  always_comb begin
    sts.kind = kind_r;
    sts.mode = mode_r;
    unique case (mode_r)
      MODE_HEAD_TAIL: sts.pre_ok = len >= h + t;
      MODE_NEXT_HEAD: sts.pre_ok = len >= h + h;
      default:        sts.pre_ok = len >= nfix;
    endcase
    sts.outer_ok  = (mode_r == MODE_NEXT_HEAD) ? (s + h <= len) : (s <= len);
    sts.inner_ok  = ti + c2 + s <= len;
    sts.chk_done  = x >= csel;
    sts.chk_oob   = pos + x >= len;
    sts.byte_eq   = rdata == pbyte;
    sts.size_zero = size_r == '0;
    sts.emit_last = k + CNT_W'(1) == size_r;
    sts.out_busy  = out_valid && !out_ch.ready;
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      wp        <= '0;
      chunk_acc <= 1'b0;
      out_valid <= 1'b0;
      mode_r    <= MODE_HEAD_TAIL;
      head_pat  <= '0;
      head_cnt  <= '0;
      tail_pat  <= '0;
      tail_cnt  <= '0;
      fixed_len <= 6'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:         mode_r    <= cfg_data[1:0];
          REG_HEAD_PATTERN: head_pat  <= cfg_data[PB-1:0];
          REG_HEAD_COUNT:   head_cnt  <= cfg_data[3:0];
          REG_TAIL_PATTERN: tail_pat  <= cfg_data[PB-1:0];
          REG_TAIL_COUNT:   tail_cnt  <= cfg_data[3:0];
          REG_FIXED_LENGTH: fixed_len <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_WRITE) begin
        chunk_acc <= wr_store;
        if (wr_store) begin
          wp <= wrap(CNT_W'(wp) + CNT_W'(1));
        end
      end
      if (cmd.op == OP_EMIT_LOAD && sts.emit_last) begin
        rp <= wrap(CNT_W'(rp) + start_r + size_r);
      end
      if (cmd.op == OP_EMIT_LOAD || cmd.op == OP_LOAD_NF || cmd.op == OP_LOAD_W) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers, result payload and byte store
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TAKE: begin
        kind_r  <= in_kind;
        data_r  <= in_data_byte;
        first_r <= in_chunk_first;
        clen_r  <= in_chunk_length;
        len     <= stored_len;
      end
      OP_WRITE: begin
        stored_r <= wr_store;
        if (wr_store) begin
          mem[wp] <= data_r;
        end
      end
      OP_START: begin
        x <= '0;
        unique case (mode_r)
          MODE_HEAD_TAIL: s <= len - h - t;
          MODE_HEAD_LEN:  s <= len - nfix;
          default:        s <= '0;
        endcase
      end
      OP_READ, OP_EMIT_RD: rdata <= mem[rd_addr];
      OP_CHK_NEXT: x <= x + CNT_W'(1);
      OP_OUTER_NEXT: begin
        x <= '0;
        s <= (mode_r == MODE_NEXT_HEAD) ? (s + CNT_W'(1)) : (s - CNT_W'(1));
      end
      OP_INNER_INIT: begin
        ti <= h;
        x  <= '0;
      end
      OP_INNER_NEXT: begin
        ti <= ti + CNT_W'(1);
        x  <= '0;
      end
      OP_FOUND: begin
        start_r <= s;
        k       <= '0;
        unique case (mode_r)
          MODE_HEAD_TAIL: size_r <= ti + t;
          MODE_NEXT_HEAD: size_r <= ti;
          default:        size_r <= nfix;
        endcase
      end
      OP_EMIT_LOAD: begin
        out_ch.write_accepted <= 1'b0;
        out_ch.found          <= 1'b1;
        out_ch.frame_byte     <= rdata;
        out_ch.frame_size     <= 6'(size_r);
        out_ch.last           <= sts.emit_last;
        k                     <= k + CNT_W'(1);
      end
      OP_LOAD_NF, OP_LOAD_W: begin
        out_ch.write_accepted <= (cmd.op == OP_LOAD_W) && stored_r;
        out_ch.found          <= 1'b0;
        out_ch.frame_byte     <= '0;
        out_ch.frame_size     <= '0;
        out_ch.last           <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid;

  `BRFE_ASSERT_NEXT(a_full_drop, (cmd.op == OP_WRITE && room == '0), !chunk_acc, "full buffer kept chunk open")
  `BRFE_ASSERT_IMPL(a_emit_range, (cmd.op == OP_EMIT_RD), (start_r + k < len), "frame read past stored data")
  `BRFE_ASSERT_IMPL(a_len_bound, (cmd.op == OP_TAKE), (stored_len < DEPTH), "stored length reached depth")

endmodule

/* design/brfe_controller.sv */
// ----------------------------------------------------------------------------
// brfe_controller
// Sequencer for write, search and frame emission.
// ----------------------------------------------------------------------------
`include "byte_ring_frame_extractor_macros.svh"

module brfe_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  brfe_pkg::dp_sts_t sts,
  output brfe_pkg::dp_cmd_t cmd
);
  import brfe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRE,
    ST_OUTER_TEST,
    ST_H_ISSUE,
    ST_H_CMP,
    ST_I_TEST,
    ST_I_ISSUE,
    ST_I_CMP,
    ST_SET_FOUND,
    ST_CHK_SIZE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_NF_OUT,
    ST_W_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.inner  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_TAKE;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.kind == KIND_WRITE) begin
          cmd.op     = OP_WRITE;
          state_next = ST_W_OUT;
        end else begin
          cmd.op     = OP_START;
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        if (!sts.pre_ok) begin
          state_next = ST_NF_OUT;
        end else if (sts.mode == MODE_LEN_ONLY) begin
          state_next = ST_SET_FOUND;
        end else begin
          state_next = ST_OUTER_TEST;
        end
      end
      ST_OUTER_TEST: begin
        state_next = sts.outer_ok ? ST_H_ISSUE : ST_NF_OUT;
      end
      ST_H_ISSUE: begin
        priority if (sts.chk_done) begin
          if (sts.mode == MODE_HEAD_LEN) begin
            state_next = ST_SET_FOUND;
          end else begin
            cmd.op     = OP_INNER_INIT;
            state_next = ST_I_TEST;
          end
        end else if (sts.chk_oob) begin
          cmd.op     = OP_OUTER_NEXT;
          state_next = ST_OUTER_TEST;
        end else begin
          cmd.op     = OP_READ;
          state_next = ST_H_CMP;
        end
      end
      ST_H_CMP: begin
        if (sts.byte_eq) begin
          cmd.op     = OP_CHK_NEXT;
          state_next = ST_H_ISSUE;
        end else begin
          cmd.op     = OP_OUTER_NEXT;
          state_next = ST_OUTER_TEST;
        end
      end
      ST_I_TEST: begin
        cmd.inner = 1'b1;
        if (sts.inner_ok) begin
          state_next = ST_I_ISSUE;
        end else begin
          cmd.op     = OP_OUTER_NEXT;
          state_next = ST_OUTER_TEST;
        end
      end
      ST_I_ISSUE: begin
        cmd.inner = 1'b1;
        priority if (sts.chk_done) begin
          state_next = ST_SET_FOUND;
        end else if (sts.chk_oob) begin
          cmd.op     = OP_INNER_NEXT;
          state_next = ST_I_TEST;
        end else begin
          cmd.op     = OP_READ;
          state_next = ST_I_CMP;
        end
      end
      ST_I_CMP: begin
        cmd.inner = 1'b1;
        if (sts.byte_eq) begin
          cmd.op     = OP_CHK_NEXT;
          state_next = ST_I_ISSUE;
        end else begin
          cmd.op     = OP_INNER_NEXT;
          state_next = ST_I_TEST;
        end
      end
      ST_SET_FOUND: begin
        cmd.op     = OP_FOUND;
        state_next = ST_CHK_SIZE;
      end
      ST_CHK_SIZE: begin
        state_next = sts.size_zero ? ST_NF_OUT : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        cmd.op     = OP_EMIT_RD;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_EMIT_LOAD;
          state_next = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_NF_OUT: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_LOAD_NF;
          state_next = ST_IDLE;
        end
      end
      ST_W_OUT: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_LOAD_W;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BRFE_ASSERT_IMPL(a_load_free, (cmd.op == OP_EMIT_LOAD || cmd.op == OP_LOAD_NF || cmd.op == OP_LOAD_W), !sts.out_busy, "result loaded over a waiting result")
  `BRFE_ASSERT_NEXT(a_last_idle, (cmd.op == OP_EMIT_LOAD && sts.emit_last), (state == ST_IDLE), "no return to idle after final frame byte")
  `BRFE_ASSERT_NEXT(a_take_decode, (in_valid && in_ready), (state == ST_DECODE), "accepted item not decoded")

endmodule

/* design/byte_ring_frame_extractor.sv */
// ----------------------------------------------------------------------------
// byte_ring_frame_extractor
// Byte ring buffer with chunked writes and frame extraction.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A write item is accepted, stored and then
// answered with one result. An extract item is accepted and set up, then the
// search walks the stored bytes through the single read port of the byte
// store, reading and then comparing each byte, then the frame leaves byte by
// byte, each read through that port and loaded. A no-frame answer is one
// result. Results sit in an output register, so a stalled consumer holds the
// block only when the next result is due. The byte store needs no clearing
// pass after reset: only written entries are ever read. Configuration writes
// are always taken and must land while the block is idle.
// ----------------------------------------------------------------------------
module byte_ring_frame_extractor #(
  parameter int BUFFER_DEPTH      = brfe_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_PATTERN_BYTES = brfe_pkg::MAX_PATTERN_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  brfe_in_if.sink    in_ch,
  brfe_out_if.source out_ch,
  brfe_cfg_if.sink   cfg_ch
);
  import brfe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // take configuration writes in every cycle
  assign cfg_ch.ready = 1'b1;

  brfe_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brfe_datapath #(
    .BUFFER_DEPTH      (BUFFER_DEPTH),
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_data_byte    (in_ch.data_byte),
    .in_chunk_first  (in_ch.chunk_first),
    .in_chunk_length (in_ch.chunk_length),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_ch          (out_ch)
  );

endmodule

/* tb/sv/byte_ring_frame_extractor_test.sv */
// ----------------------------------------------------------------------------
// byte_ring_frame_extractor_test
// Drives chunked byte writes and frame extract requests into the ring buffer
// under every search mode. Expected results come from a behavioural copy of
// the ring kept in the bench. Each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module byte_ring_frame_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brfe_pkg::*;

  localparam logic KIND_EXTRACT = ~KIND_WRITE;
  localparam int   RING_DEPTH   = 64;
  localparam int   PAT_MAX      = 8;
  localparam int   IDLE_LIMIT   = 400000;

  typedef struct {
    logic       write_accepted;
    logic       found;
    logic [7:0] frame_byte;
    logic [5:0] frame_size;
    logic       last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  brfe_in_if  in_ch ();
  brfe_out_if out_ch ();
  brfe_cfg_if cfg_ch ();

  byte_ring_frame_extractor u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Behavioural copy of the ring and its registers
  logic [7:0]  ring_bytes [RING_DEPTH];
  logic [5:0]  rd_ptr;
  logic [5:0]  wr_ptr;
  bit          chunk_open;
  logic [1:0]  cur_mode;
  logic [63:0] cur_head;
  int          cur_head_cnt;
  logic [63:0] cur_tail;
  int          cur_tail_cnt;
  int          cur_fixed_len;

  frame_result_t expected_results[$];
  int            mismatch_count = 0;

  // Idling controls
  bit stall_en   = 1'b0;
  bit gap_en     = 1'b0;
  int hold_req   = 0;
  int hold_left  = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Ring predictor
  // ---------------------------------------------------------------------------
  function automatic int fill_level();
    return (int'(wr_ptr) - int'(rd_ptr) + RING_DEPTH) % RING_DEPTH;
  endfunction

  function automatic logic [7:0] peek(int off);
    return ring_bytes[(int'(rd_ptr) + off) % RING_DEPTH];
  endfunction

  // positions at or past the fill level never match
  function automatic bit pattern_here(logic [63:0] pat, int cnt, int pos, int len);
    for (int x = 0; x < cnt; x++) begin
      if (pos + x >= len) return 1'b0;
      if (peek(pos + x) != pat[8*x +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit locate_frame(int len, output int start, output int size);
    int h;
    int t;
    int n;
    h = (cur_head_cnt > PAT_MAX) ? PAT_MAX : cur_head_cnt;
    t = (cur_tail_cnt > PAT_MAX) ? PAT_MAX : cur_tail_cnt;
    n = cur_fixed_len;
    start = 0;
    size = 0;
    case (cur_mode)
      MODE_HEAD_TAIL: begin
        if (len < h + t) return 1'b0;
        for (int s = len - h - t; s >= 0; s--) begin
          if (!pattern_here(cur_head, h, s, len)) continue;
          for (int ti = h; ti + t + s <= len; ti++) begin
            if (pattern_here(cur_tail, t, s + ti, len)) begin
              start = s;
              size = ti + t;
              return 1'b1;
            end
          end
        end
        return 1'b0;
      end
      MODE_HEAD_LEN: begin
        if (len < n) return 1'b0;
        for (int s = len - n; s >= 0; s--) begin
          if (pattern_here(cur_head, h, s, len)) begin
            start = s;
            size = n;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      MODE_LEN_ONLY: begin
        if (len < n) return 1'b0;
        size = n;
        return 1'b1;
      end
      default: begin
        if (len < 2 * h) return 1'b0;
        for (int s = 0; s + h <= len; s++) begin
          if (!pattern_here(cur_head, h, s, len)) continue;
          for (int ti = h; ti + h + s <= len; ti++) begin
            if (pattern_here(cur_head, h, s + ti, len)) begin
              start = s;
              size = ti;
              return 1'b1;
            end
          end
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Work out the results of one accepted item and advance the ring copy
  function automatic void predict_item(logic kind, logic [7:0] data, logic first,
                                       logic [5:0] clen);
    frame_result_t r;
    int len;
    int room;
    int start;
    int size;
    bit hit;
    len = fill_level();
    r = '{default: '0};
    r.last = 1'b1;
    if (kind == KIND_WRITE) begin
      room = RING_DEPTH - 1 - len;
      if (first) chunk_open = (int'(clen) <= room);
      if (chunk_open) begin
        if (room == 0) begin
          chunk_open = 1'b0;
        end else begin
          ring_bytes[wr_ptr] = data;
          wr_ptr = wr_ptr + 6'd1;
          r.write_accepted = 1'b1;
        end
      end
      expected_results.push_back(r);
      return;
    end
    hit = locate_frame(len, start, size);
    if (!hit || size == 0) begin
      expected_results.push_back(r);
      return;
    end
    for (int k = 0; k < size; k++) begin
      r.found = 1'b1;
      r.frame_byte = peek(start + k);
      r.frame_size = size[5:0];
      r.last = (k + 1 == size);
      expected_results.push_back(r);
    end
    rd_ptr = 6'((int'(rd_ptr) + start + size) % RING_DEPTH);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: frame_byte %0h", out_ch.frame_byte);
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.write_accepted !== e.write_accepted) begin
          $error("write_accepted: expected %0d, got %0d", e.write_accepted,
                 out_ch.write_accepted);
          mismatch_count++;
        end
        if (out_ch.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_ch.found);
          mismatch_count++;
        end
        if (out_ch.frame_byte !== e.frame_byte) begin
          $error("frame_byte: expected %0h, got %0h", e.frame_byte, out_ch.frame_byte);
          mismatch_count++;
        end
        if (out_ch.frame_size !== e.frame_size) begin
          $error("frame_size: expected %0d, got %0d", e.frame_size, out_ch.frame_size);
          mismatch_count++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted down here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!stall_en) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      // mostly short stalls, now and then a long one
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                : $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  // Offer one item and hold valid until it is taken; drop valid only for a gap
  task automatic send_item(logic kind, logic [7:0] data, logic first, logic [5:0] clen);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.data_byte    <= data;
    in_ch.chunk_first  <= first;
    in_ch.chunk_length <= clen;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(kind, data, first, clen);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a well-formed chunk: the declared length matches the byte count
  task automatic send_chunk(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(KIND_WRITE, bytes[i], i == 0, 6'(bytes.size()));
  endtask

  task automatic extract_frame();
    send_item(KIND_EXTRACT, 8'($urandom), 1'($urandom), 6'($urandom));
  endtask

  // Hold the input and wait until every expected result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write one register; the block must be idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MODE:         cur_mode = data[1:0];
      REG_HEAD_PATTERN: cur_head = data;
      REG_HEAD_COUNT:   cur_head_cnt = int'(data[3:0]);
      REG_TAIL_PATTERN: cur_tail = data;
      REG_TAIL_COUNT:   cur_tail_cnt = int'(data[3:0]);
      REG_FIXED_LENGTH: cur_fixed_len = int'(data[5:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty buffer, zero-length frames and a dropped chunk under reset settings
  task automatic test_defaults_and_drop();
    extract_frame();                     // empty: no frame
    send_chunk('{8'hAA, 8'hBB});
    extract_frame();                     // no header, no trailer: zero length
    send_item(KIND_WRITE, 8'h00, 1'b1, 6'd63);  // too big for the room: drop
    send_item(KIND_WRITE, 8'hFF, 1'b0, 6'd63);  // rest of the dropped chunk
    drain();
    write_reg(REG_MODE, MODE_LEN_ONLY);
    write_reg(REG_FIXED_LENGTH, 0);
    extract_frame();                     // fixed length zero: no frame
    drain();
    write_reg(REG_FIXED_LENGTH, 2);
    extract_frame();                     // takes AA BB
    drain();
  endtask

  // One frame in each header-based search mode, with a two-byte header
  task automatic test_each_mode();
    write_reg(REG_HEAD_PATTERN, 64'h5AA5);
    write_reg(REG_HEAD_COUNT, 2);
    write_reg(REG_TAIL_PATTERN, 64'h0D);
    write_reg(REG_TAIL_COUNT, 1);
    write_reg(REG_MODE, MODE_HEAD_TAIL);
    send_chunk('{8'h00, 8'hA5, 8'h5A, 8'h11, 8'h0D});
    extract_frame();
    drain();
    write_reg(REG_MODE, MODE_HEAD_LEN);
    write_reg(REG_FIXED_LENGTH, 3);
    send_chunk('{8'hA5, 8'h5A, 8'h22, 8'hFF});
    extract_frame();                     // leaves FF behind
    drain();
    write_reg(REG_MODE, MODE_NEXT_HEAD);
    send_chunk('{8'hA5, 8'h5A, 8'h33, 8'hA5, 8'h5A});
    extract_frame();                     // header up to the next header
    drain();
  endtask

  // Hold the receiver off while an overlong chunk keeps coming: the buffer
  // fills, the byte that finds it full is dropped, and the input stalls
  task automatic test_backpressure_overflow();
    write_reg(REG_MODE, MODE_LEN_ONLY);
    write_reg(REG_FIXED_LENGTH, 63);
    @(posedge clk);
    hold_req = 500;
    for (int i = 0; i < 70; i++) send_item(KIND_WRITE, 8'($urandom), i == 0, 6'd5);
    extract_frame();                     // 63 bytes, empties the ring
    drain();                             // pause until every result is in
  endtask

  // Random phases: new settings each time, mostly well-formed frames
  task automatic test_random_phases();
    logic [7:0] bytes[$];
    int sent;
    int h;
    int t;
    int pick;
    int nbytes;
    logic [5:0] clen;
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      stall_en = (ph % 3 != 0);
      gap_en   = (ph % 3 != 0);
      write_reg(REG_MODE, ph % 4);
      case (ph)
        0: begin
          write_reg(REG_HEAD_PATTERN, '1);
          write_reg(REG_HEAD_COUNT, 8);
        end
        1: begin
          write_reg(REG_HEAD_PATTERN, '0);
          write_reg(REG_HEAD_COUNT, 15);
        end
        default: begin
          write_reg(REG_HEAD_PATTERN, {$urandom, $urandom});
          write_reg(REG_HEAD_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(1, 3));
        end
      endcase
      write_reg(REG_TAIL_PATTERN, (ph == 2) ? '1 : {$urandom, $urandom});
      write_reg(REG_TAIL_COUNT, (ph == 4) ? 15 : $urandom_range(0, 3));
      write_reg(REG_FIXED_LENGTH, (ph == 5) ? 63 : (ph == 6) ? 0 : $urandom_range(1, 12));
      h = (cur_head_cnt > PAT_MAX) ? PAT_MAX : cur_head_cnt;
      t = (cur_tail_cnt > PAT_MAX) ? PAT_MAX : cur_tail_cnt;
      sent = 0;
      while (sent < 16) begin
        pick = $urandom_range(0, 99);
        bytes.delete();
        if (pick < 55) begin
          // header, random body, and a trailer in head-tail mode
          for (int x = 0; x < h; x++) bytes.push_back(cur_head[8*x +: 8]);
          repeat ($urandom_range(0, 8)) bytes.push_back(8'($urandom));
          if (cur_mode == MODE_HEAD_TAIL)
            for (int x = 0; x < t; x++) bytes.push_back(cur_tail[8*x +: 8]);
          if (bytes.size() == 0) bytes.push_back(8'($urandom));
          send_chunk(bytes);
          sent += bytes.size();
        end else if (pick < 72) begin
          // noise: any declared length, one to six bytes
          nbytes = $urandom_range(1, 6);
          clen = 6'($urandom_range(0, 63));
          for (int i = 0; i < nbytes; i++)
            send_item(KIND_WRITE, 8'($urandom), (i == 0) || ($urandom_range(0, 7) == 0), clen);
          sent += nbytes;
        end else begin
          extract_frame();
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_WRITE;
    in_ch.data_byte    = '0;
    in_ch.chunk_first  = 1'b0;
    in_ch.chunk_length = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_MODE;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    foreach (ring_bytes[i]) ring_bytes[i] = '0;
    rd_ptr        = '0;
    wr_ptr        = '0;
    chunk_open    = 1'b0;
    cur_mode      = MODE_HEAD_TAIL;
    cur_head      = '0;
    cur_head_cnt  = 0;
    cur_tail      = '0;
    cur_tail_cnt  = 0;
    cur_fixed_len = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults_and_drop();
    test_each_mode();
    test_backpressure_overflow();
    test_random_phases();

    // let any trailing activity settle before the verdict
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/brfe_pkg.sv
design/brfe_in_if.sv
design/brfe_out_if.sv
design/brfe_cfg_if.sv
design/brfe_datapath.sv
design/brfe_controller.sv
design/byte_ring_frame_extractor.sv
tb/sv/byte_ring_frame_extractor_test.sv
